/* src/rate_limited_history_ring_unit_macros.svh */
// ----------------------------------------------------------------------------
// rate limited history ring: assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef RATE_LIMITED_HISTORY_RING_UNIT_MACROS_SVH
`define RATE_LIMITED_HISTORY_RING_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked on clk, ignored while rst_n is low
`define RLHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on clk at every edge, reset included
`define RLHR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLHR_ASSERT(lbl, prop, msg)
`define RLHR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/rlhr_pkg.sv */
// ----------------------------------------------------------------------------
// rlhr_pkg
// shared types and constants of the rate limited history ring
// ----------------------------------------------------------------------------
package rlhr_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned SVAL_W = 16;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned HELD_W = 8;

  // quotient of the average never exceeds 100
  localparam int unsigned QUO_W = PCT_W;

  // q8.8 percentage handling
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned Q88_W  = 15;
  localparam logic [Q88_W-1:0] PCT_MAX_Q88 = 15'd25600;
  localparam logic [Q88_W-1:0] Q88_HALF    = 15'd128;

  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd3600000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_ENTRY  = 2'd1,
    FUNC_PEAK   = 2'd2,
    FUNC_AVG    = 2'd3
  } func_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* src/rlhr_div.sv */
// ----------------------------------------------------------------------------
// rlhr_div
// restoring divider for the average, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rlhr_div #(
  parameter int unsigned CNT_W = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [CNT_W+rlhr_pkg::QUO_W-1:0]        dividend,
  input  logic [CNT_W-1:0]                        divisor,
  output rlhr_pkg::div_status_t                   status,
  output logic [rlhr_pkg::QUO_W-1:0]              quotient
);
  import rlhr_pkg::*;

  localparam int unsigned ACC_W  = CNT_W + QUO_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic [ACC_W-1:0]  rem_r;
  logic [ACC_W-1:0]  dsh_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  // dividend < 2^QUO_W * divisor, so QUO_W steps cover the quotient
  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend;
        dsh_r  <= ACC_W'(divisor) << (QUO_W - 1);
        quo_r  <= '0;
        step_r <= STEP_W'(QUO_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[QUO_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

/* src/rate_limited_history_ring_unit.sv */
// ----------------------------------------------------------------------------
// rate_limited_history_ring_unit
// ring history of percentage samples with entry read, peak and average
// ----------------------------------------------------------------------------
// One item is worked on at a time and every item gives exactly one result.
// A sample item (func 0) is stored only for the first sample or once at least
// sample_interval time units have passed since the last stored one (wrapping
// 32-bit difference); its q8.8 value is clamped to 0..100, rounded half up and
// written at the head of the ring, overwriting the oldest entry when full.
// Func 1 returns the entry at entry_index counted from the oldest (clamped to
// the held range), func 2 the peak and func 3 the truncated average of the
// held entries; all give 0 on an empty ring. The history lives in one
// CAPACITY x 7 synchronous memory with one read and one write port. A sample
// or any read of an empty ring goes from the execute state straight to the
// result stage, while an entry read passes through the registered memory
// read first; peak and average walk the memory read port one entry per cycle
// and the average then runs a 7-step divider. The next item is taken once
// the previous result sits in the output register. The configuration port
// is always ready and must only be written while idle.
// ----------------------------------------------------------------------------
`include "rate_limited_history_ring_unit_macros.svh"

module rate_limited_history_ring_unit #(
  parameter int unsigned CAPACITY = 168
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // now_time[31:0], sample_value[47:32], entry_index[57:48]
  input  logic [1:0]  in_tuser,   // func[1:0]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_value[6:0], entries_held[14:7]
  output logic        out_tuser,  // sample_taken[0]
  // sample_interval register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import rlhr_pkg::*;

  localparam int unsigned PW    = $clog2(CAPACITY);      // ring address
  localparam int unsigned FW    = $clog2(CAPACITY + 1);  // fill count
  localparam int unsigned ACC_W = FW + QUO_W;            // sum of entries
  localparam int unsigned CW    = (FW > IDX_W - 1) ? FW : IDX_W - 1;
  localparam logic [FW-1:0] FILL_CAP = FW'(CAPACITY);
  localparam logic [PW:0]   POS_CAP  = (PW + 1)'(CAPACITY);
  localparam logic [PW-1:0] POS_LAST = PW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_DIV,
    S_EMIT
  } state_t;

  state_t             state_r;

  // latched input item
  func_t              func_r;
  logic [TIME_W-1:0]  now_r;
  logic [SVAL_W-1:0]  sval_r;
  logic [IDX_W-1:0]   idx_r;

  // ring state
  logic [TIME_W-1:0]  interval_r;
  logic [PW-1:0]      write_pos_r;
  logic [FW-1:0]      fill_level_r;
  logic [TIME_W-1:0]  last_time_r;
  logic               any_taken_r;

  // walk over held entries
  logic [FW-1:0]      scan_cnt_r;
  logic               rd_pend_r;
  logic [ACC_W-1:0]   acc_r;
  logic [PCT_W-1:0]   max_r;

  // staged result and output register
  logic               res_taken_r;
  logic [PCT_W-1:0]   res_value_r;
  logic               out_tvalid_r;
  logic               out_taken_r;
  logic [PCT_W-1:0]   out_value_r;
  logic [HELD_W-1:0]  out_held_r;
  logic               out_load;

  // history memory
  logic [PCT_W-1:0]   hist_mem [CAPACITY];
  logic [PCT_W-1:0]   rd_data_r;
  logic               mem_we;
  logic               mem_re;
  logic [PW-1:0]      mem_raddr;

  // combinational helpers
  logic [TIME_W-1:0]  elapsed;
  logic               sample_take;
  logic [Q88_W-1:0]   pct_q88;
  logic [Q88_W-1:0]   rnd_sum;
  logic [PCT_W-1:0]   sample_pct;
  logic [CW-1:0]      idx_c;
  logic [CW-1:0]      fill_c;
  logic [PW-1:0]      idx_cl;
  logic [PW:0]        pos_sum;
  logic [PW-1:0]      entry_pos;
  logic               ring_full;
  logic               ring_empty;
  logic               scan_end;

  logic               div_start;
  div_status_t        div_st;
  logic [QUO_W-1:0]   div_quo;

  // ---------------------------------------------------------------------------
  // sample acceptance: wrapping elapsed time against the interval
  // ---------------------------------------------------------------------------
  assign elapsed     = now_r - last_time_r;
  assign sample_take = !any_taken_r || (elapsed >= interval_r);

  // clamp to 0..100.0 in q8.8, then round half up
  always_comb begin
    if (sval_r[SVAL_W-1]) begin
      pct_q88 = '0;
    end else if (sval_r[Q88_W-1:0] > PCT_MAX_Q88) begin
      pct_q88 = PCT_MAX_Q88;
    end else begin
      pct_q88 = sval_r[Q88_W-1:0];
    end
  end

  assign rnd_sum    = pct_q88 + Q88_HALF;
  assign sample_pct = rnd_sum[FRAC_W +: PCT_W];

  // ---------------------------------------------------------------------------
  // entry position: oldest entry sits at 0 until the ring wraps, then at the
  // write pointer
  // ---------------------------------------------------------------------------
  assign ring_full  = (fill_level_r == FILL_CAP);
  assign ring_empty = (fill_level_r == '0);

  always_comb begin
    idx_c  = CW'(idx_r[IDX_W-2:0]);
    fill_c = CW'(fill_level_r);
    if (idx_r[IDX_W-1]) begin
      idx_cl = '0;
    end else if (idx_c >= fill_c) begin
      idx_cl = PW'(fill_level_r - 1'b1);
    end else begin
      idx_cl = PW'(idx_c);
    end
    pos_sum = (PW + 1)'(write_pos_r) + (PW + 1)'(idx_cl);
    if (!ring_full) begin
      entry_pos = idx_cl;
    end else if (pos_sum >= POS_CAP) begin
      entry_pos = PW'(pos_sum - POS_CAP);
    end else begin
      entry_pos = PW'(pos_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // memory ports
  // ---------------------------------------------------------------------------
  // held entries are always the raw addresses below fill, in any order
  assign scan_end = (scan_cnt_r == fill_level_r) && !rd_pend_r;

  assign mem_we = (state_r == S_EXEC) && (func_r == FUNC_SAMPLE) && sample_take;
  assign mem_re = ((state_r == S_EXEC) && (func_r == FUNC_ENTRY) && !ring_empty) ||
                  ((state_r == S_SCAN) && (scan_cnt_r < fill_level_r));
  assign mem_raddr = (state_r == S_EXEC) ? entry_pos : scan_cnt_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[write_pos_r] <= sample_pct;
    end
    if (mem_re) begin
      rd_data_r <= hist_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // average divider
  // ---------------------------------------------------------------------------
  assign div_start = (state_r == S_SCAN) && scan_end && (func_r == FUNC_AVG);

  rlhr_div #(
    .CNT_W    (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (fill_level_r),
    .status   (div_st),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // sequencer, ring state and output register
  // ---------------------------------------------------------------------------
  // result moves into the output slot when the slot is free or draining
  assign out_load = (state_r == S_EMIT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      interval_r   <= INTERVAL_RESET;
      write_pos_r  <= '0;
      fill_level_r <= '0;
      last_time_r  <= '0;
      any_taken_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval_r <= cfg_data;
      end

      // output slot fills from the sequencer, drains on its own
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r  <= func_t'(in_tuser);
            now_r   <= in_tdata[31:0];
            sval_r  <= in_tdata[47:32];
            idx_r   <= in_tdata[57:48];
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_taken_r <= 1'b0;
          res_value_r <= '0;
          scan_cnt_r  <= '0;
          rd_pend_r   <= 1'b0;
          acc_r       <= '0;
          max_r       <= '0;
          case (func_r)
            FUNC_SAMPLE: begin
              if (sample_take) begin
                any_taken_r <= 1'b1;
                last_time_r <= now_r;
                write_pos_r <= (write_pos_r == POS_LAST) ? '0 : write_pos_r + 1'b1;
                if (!ring_full) begin
                  fill_level_r <= fill_level_r + 1'b1;
                end
                res_taken_r <= 1'b1;
                res_value_r <= sample_pct;
              end
              state_r <= S_EMIT;
            end
            FUNC_ENTRY: begin
              state_r <= ring_empty ? S_EMIT : S_READ;
            end
            default: begin
              // peak and average both walk the held entries
              state_r <= ring_empty ? S_EMIT : S_SCAN;
            end
          endcase
        end

        S_READ: begin
          res_value_r <= rd_data_r;
          state_r     <= S_EMIT;
        end

        S_SCAN: begin
          if (mem_re) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
          rd_pend_r <= mem_re;
          if (rd_pend_r) begin
            acc_r <= acc_r + ACC_W'(rd_data_r);
            if (rd_data_r > max_r) begin
              max_r <= rd_data_r;
            end
          end
          if (scan_end) begin
            if (func_r == FUNC_PEAK) begin
              res_value_r <= max_r;
              state_r     <= S_EMIT;
            end else begin
              state_r <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_st.done) begin
            res_value_r <= div_quo;
            state_r     <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_load) begin
            out_taken_r  <= res_taken_r;
            out_value_r  <= res_value_r;
            out_held_r   <= HELD_W'(fill_level_r);
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_taken_r;
  assign out_tdata  = {1'b0, out_held_r, out_value_r};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `RLHR_ASSERT(a_fill_bound, fill_level_r <= FILL_CAP, "fill level beyond capacity")
  `RLHR_ASSERT(a_wp_tracks_fill, (fill_level_r != FILL_CAP) |-> (FW'(write_pos_r) == fill_level_r), "write pointer off fill before wrap")
  `RLHR_ASSERT(a_fill_grows, (mem_we && !ring_full) |=> (fill_level_r == FW'($past(fill_level_r) + 1'b1)), "stored sample did not grow fill")
  `RLHR_ASSERT(a_scan_in_range, (mem_re && (state_r == S_SCAN)) |-> (FW'(mem_raddr) < fill_level_r), "walk read beyond held entries")
  `RLHR_ASSERT(a_div_done_in_div, div_st.done |-> (state_r == S_DIV), "divider finished outside average wait")

endmodule

/* tb/rate_limited_history_ring_unit_tb.sv */
// ----------------------------------------------------------------------------
// rate_limited_history_ring_unit_tb
// self-checking bench for the rate limited history ring unit
// ----------------------------------------------------------------------------
// Items go in on the input stream and a scoreboard works out each result
// with its own copy of the ring, the fill level, the last stored timestamp
// and the sample interval. Every result item is checked field by field
// against the oldest expected one. A directed opening covers the empty ring,
// clamping and half-up rounding, refused samples, the timestamp wrap and
// out of range indexes. Random phases follow, each with its own interval
// (zero, small, the reset value, the maximum and a random one), written
// only while the block is idle. Both sides idle at random, with a stretch
// of no random idling, a long receiver hold-off and one full drain midway.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rate_limited_history_ring_unit_tb;
  import rlhr_pkg::*;

  localparam int unsigned RING_DEPTH = 168;

  typedef struct {
    bit       taken;
    bit [6:0] value;
    bit [7:0] held;
  } ring_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own model of the ring plus the queue of expected results
  // --------------------------------------------------------------------------
  class ring_scoreboard;
    bit [6:0]     history[RING_DEPTH];
    int unsigned  head;
    int unsigned  fill;
    bit [31:0]    last_stamp;
    bit           ever_stored;
    bit [31:0]    interval;
    ring_result_t awaited[$];
    int unsigned  errors;
    int unsigned  results_checked;
    int unsigned  n_stored, n_refused, n_entry, n_peak, n_avg, n_overwrite;

    function new();
      head = 0;
      fill = 0;
      last_stamp = '0;
      ever_stored = 0;
      interval = INTERVAL_RESET;
      errors = 0;
      results_checked = 0;
      n_stored = 0; n_refused = 0; n_entry = 0;
      n_peak = 0; n_avg = 0; n_overwrite = 0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void set_interval(bit [31:0] v);
      interval = v;
    endfunction

    function int unsigned pending_count();
      return awaited.size();
    endfunction

    // entry counted from the oldest, index clamped to the held range
    function bit [6:0] held_entry(int pos);
      int unsigned oldest;
      if (fill == 0) return '0;
      if (pos < 0) pos = 0;
      if (pos >= int'(fill)) pos = int'(fill) - 1;
      oldest = (head + RING_DEPTH - fill) % RING_DEPTH;
      return history[(oldest + pos) % RING_DEPTH];
    endfunction

    // expected result of one accepted request
    function ring_result_t ring_response(func_t f, bit [31:0] now,
                                         bit signed [15:0] sval,
                                         bit signed [9:0] idx);
      ring_result_t r;
      int           v;
      int           pos;
      int unsigned  sum;
      bit [31:0]    elapsed;
      r.taken = 0;
      r.value = '0;
      elapsed = now - last_stamp;
      case (f)
        FUNC_SAMPLE: begin
          if (!ever_stored || elapsed >= interval) begin
            v = sval;
            if (v < 0) v = 0;
            if (v > 25600) v = 25600;
            r.value = 7'((v + 128) >> 8);
            r.taken = 1;
            ever_stored = 1;
            last_stamp = now;
            if (fill == RING_DEPTH) n_overwrite++;
            history[head] = r.value;
            head = (head + 1) % RING_DEPTH;
            if (fill < RING_DEPTH) fill++;
            n_stored++;
          end else begin
            n_refused++;
          end
        end
        FUNC_ENTRY: begin
          pos = idx;
          r.value = held_entry(pos);
          n_entry++;
        end
        FUNC_PEAK: begin
          for (int i = 0; i < int'(fill); i++)
            if (held_entry(i) > r.value) r.value = held_entry(i);
          n_peak++;
        end
        default: begin
          sum = 0;
          for (int i = 0; i < int'(fill); i++) sum += held_entry(i);
          if (fill != 0) r.value = 7'(sum / fill);
          n_avg++;
        end
      endcase
      r.held = 8'(fill);
      return r;
    endfunction

    function void note_input(func_t f, bit [31:0] now, bit [15:0] sval,
                             bit [9:0] idx);
      awaited.push_back(ring_response(f, now, sval, idx));
    endfunction

    function void check_result(bit taken, bit [6:0] value, bit [7:0] held);
      ring_result_t exp_r;
      results_checked++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result item taken=%0d value=%0d held=%0d",
                 $time, taken, value, held);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (taken !== exp_r.taken) begin
        $display("%0t: sample_taken mismatch, expected %0d actual %0d",
                 $time, exp_r.taken, taken);
        errors++;
      end
      if (value !== exp_r.value) begin
        $display("%0t: result_value mismatch, expected %0d actual %0d",
                 $time, exp_r.value, value);
        errors++;
      end
      if (held !== exp_r.held) begin
        $display("%0t: entries_held mismatch, expected %0d actual %0d",
                 $time, exp_r.held, held);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // now_time[31:0], sample_value[47:32], entry_index[57:48]
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // result_value[6:0], entries_held[14:7]
  logic        out_tuser;  // sample_taken[0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  rate_limited_history_ring_unit #(.CAPACITY(RING_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ring_scoreboard sb;

  // steady: while set, the sender adds no gaps and the receiver stays ready outside the hold-off
  bit          steady;
  bit          hold_done;
  int unsigned hold_left;
  bit [31:0]   stamp;   // running timestamp for sample requests

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous fixed limit, several times the slowest legal run
  initial begin
    #10ms;
    $display("rate_limited_history_ring_unit test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // monitors: everything is sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(func_t'(in_tuser), in_tdata[31:0], in_tdata[47:32],
                    in_tdata[57:48]);
    if (rst_n && cfg_valid && cfg_ready)
      sb.set_interval(cfg_data);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[6:0], out_tdata[14:7]);
  end

  // --------------------------------------------------------------------------
  // receiver: random back-pressure, one long hold-off counted here
  // --------------------------------------------------------------------------
  initial begin
    @(negedge clk);
    forever begin
      if (!hold_done && sb.results_checked >= 500) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (steady) begin
        out_tready = 1'b1;
      end else begin
        out_tready = ($urandom_range(99) >= 32);
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks, all entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic push_item(func_t f, bit [31:0] now, bit [15:0] sval, bit [9:0] idx);
    int unsigned gap;
    if (!steady && $urandom_range(99) < 32) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = f;
    in_tdata  = {6'b0, idx, sval, now};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  // interval register, written only while idle
  task automatic write_interval(bit [31:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random q8.8 percentage, biased toward the legal range and rounding edges
  function automatic bit [15:0] pick_value();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 55) return 16'($urandom_range(0, 25600));
    if (k < 75) return 16'($urandom);
    if (k < 90) return 16'($urandom_range(0, 100) * 256 + 127 + $urandom_range(0, 1));
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'd25600;
      4: return 16'd25601;
      default: return 16'd0;
    endcase
  endfunction

  // one random request, samples move the timestamp by a step, mostly relative to the interval
  task automatic random_request();
    int unsigned k;
    bit [31:0]   step;
    bit [9:0]    idx;
    k = $urandom_range(99);
    if (k < 45) begin
      case ($urandom_range(9))
        0, 1, 2, 3: step = sb.interval + $urandom_range(0, 1000);
        4, 5:       step = sb.interval;
        6:          step = sb.interval - 1;
        7:          step = $urandom_range(0, 100);
        8:          step = $urandom;
        default:    step = '0;
      endcase
      stamp += step;
      push_item(FUNC_SAMPLE, stamp, pick_value(), 10'($urandom));
    end else begin
      if ($urandom_range(99) < 70) idx = 10'($urandom_range(0, sb.fill));
      else idx = 10'($urandom);
      if (k < 70) push_item(FUNC_ENTRY, $urandom, 16'($urandom), idx);
      else if (k < 85) push_item(FUNC_PEAK, $urandom, 16'($urandom), idx);
      else push_item(FUNC_AVG, $urandom, 16'($urandom), idx);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    sb = new();
    steady    = 0;
    hold_done = 0;
    hold_left = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // empty ring reads give zero
    push_item(FUNC_ENTRY, 32'd0, 16'd0, 10'd0);
    push_item(FUNC_PEAK, 32'hffffffff, 16'hffff, 10'h3ff);
    push_item(FUNC_AVG, 32'd0, 16'd0, 10'd0);
    // first sample always stored, most negative value clamps to zero
    push_item(FUNC_SAMPLE, 32'd0, 16'h8000, 10'd0);
    // too early: refused
    push_item(FUNC_SAMPLE, 32'd100, 16'd1000, 10'd0);
    // exactly one interval later, top of range clamps to 100
    push_item(FUNC_SAMPLE, 32'd3600000, 16'h7fff, 10'd0);
    push_item(FUNC_SAMPLE, 32'd7199999, 16'd128, 10'd0);
    // rounding: a half goes up, just under a half goes down
    push_item(FUNC_SAMPLE, 32'd7200000, 16'd128, 10'd0);
    push_item(FUNC_SAMPLE, 32'd10800000, 16'd127, 10'd0);
    push_item(FUNC_SAMPLE, 32'd14400000, 16'd25600, 10'd0);
    push_item(FUNC_SAMPLE, 32'd18000000, 16'd25601, 10'd0);
    push_item(FUNC_SAMPLE, 32'd21600000, 16'd25599, 10'd0);
    push_item(FUNC_SAMPLE, 32'd25200000, 16'h3280, 10'd0);
    // timestamp wrap: elapsed time taken modulo 2^32
    push_item(FUNC_SAMPLE, 32'hffffff00, 16'd6400, 10'd0);
    push_item(FUNC_SAMPLE, 32'd3599744, 16'hffff, 10'd0);
    push_item(FUNC_SAMPLE, 32'd3599745, 16'h7fff, 10'd0);
    // indexes below and beyond the held range
    push_item(FUNC_ENTRY, 32'd0, 16'd0, 10'h200);
    push_item(FUNC_ENTRY, 32'd0, 16'd0, 10'h1ff);
    push_item(FUNC_ENTRY, 32'd0, 16'd0, 10'h3ff);
    push_item(FUNC_ENTRY, 32'd0, 16'd0, 10'd3);
    push_item(FUNC_PEAK, 32'd0, 16'd0, 10'd0);
    push_item(FUNC_AVG, 32'd0, 16'd0, 10'd0);
    stamp = 32'd3599745;

    // interval zero: every sample stored
    write_interval(32'd0);
    for (int i = 0; i < 400; i++) begin
      if (i == 200) drain();   // sender pause until all results are back
      random_request();
    end

    // small interval, with a stretch where neither side idles at random
    write_interval(32'd1000);
    for (int i = 0; i < 200; i++) begin
      steady = (i >= 40 && i < 160);
      random_request();
    end
    steady = 0;

    // maximum interval: only an elapsed time of all ones passes
    write_interval(32'hffffffff);
    for (int i = 0; i < 100; i++) random_request();

    write_interval($urandom);
    for (int i = 0; i < 100; i++) random_request();

    write_interval(INTERVAL_RESET);
    for (int i = 0; i < 150; i++) random_request();

    write_interval(32'd1);
    for (int i = 0; i < 100; i++) random_request();

    // wind down: wait for all results back, then an idle margin before the summary
    in_tvalid = 1'b0;
    waited = 0;
    while (sb.pending_count() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);

    $display("run covered %0d stored and %0d refused samples (%0d overwrites),",
             sb.n_stored, sb.n_refused, sb.n_overwrite);
    $display("%0d entry reads, %0d peaks, %0d averages; %0d results checked",
             sb.n_entry, sb.n_peak, sb.n_avg, sb.results_checked);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("rate_limited_history_ring_unit test passed");
    end else begin
      if (sb.pending_count() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending_count());
      $display("rate_limited_history_ring_unit test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/rlhr_pkg.sv
src/rlhr_div.sv
src/rate_limited_history_ring_unit.sv
tb/rate_limited_history_ring_unit_tb.sv
